// ===== hw/rtl/lbmd1q2_pkg.sv =====
package lbmd1q2_pkg;

    localparam int OMEGA_BITS = 30;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] REG_RELAX_RATE     = 3'd0;
    localparam logic [2:0] REG_LEFT_WALL      = 3'd1;
    localparam logic [2:0] REG_RIGHT_WALL     = 3'd2;
    localparam logic [2:0] REG_LEFT_FLUX_TERM = 3'd3;
    localparam logic [2:0] REG_BOUNDARY_MODE  = 3'd4;
    localparam logic [2:0] REG_CELL_COUNT     = 3'd5;

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (OMEGA_BITS - 1);
    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    typedef struct packed {
        logic [30:0]        relax_rate;
        logic signed [31:0] left_wall;
        logic signed [31:0] right_wall;
        logic signed [31:0] left_flux_term;
        logic               boundary_mode;
    } cfg_t;

    typedef struct packed {
        logic load_item;
        logic init_wr;
        logic rd_en;
        logic rd_step;
        logic wall_wr;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/lbmd1q2_ctrl.sv =====
module lbmd1q2_ctrl #(
    parameter int MAX_CELLS = 64,
    localparam int AW = $clog2(MAX_CELLS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [1:0]              s_cmd,
    input  logic [6:0]              cell_count,
    output lbmd1q2_pkg::dp_cmd_t    dp_cmd,
    input  lbmd1q2_pkg::dp_stat_t   dp_stat,
    output logic [AW-1:0]           cell_addr,
    output logic [AW-1:0]           last_addr
);
    import lbmd1q2_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_WALL  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [AW-1:0] INIT_LAST = AW'(MAX_CELLS - 1);
    localparam logic [AW-1:0] ADDR_ONE  = AW'(1);

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    int            cells_used;

    always_comb begin
        if (cell_count < 7'd2) begin
            cells_used = 2;
        end else if (int'(cell_count) > MAX_CELLS) begin
            cells_used = MAX_CELLS;
        end else begin
            cells_used = int'(cell_count);
        end
    end

    assign last_addr = AW'(cells_used - 1);
    assign cell_addr = cnt_reg;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dp_cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dp_cmd.load_item = 1'b1;
                    cnt_next         = '0;
                    case (s_cmd)
                        CMD_INIT: state_next = ST_INIT;
                        CMD_STEP: state_next = ST_STEP;
                        CMD_READ: state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                dp_cmd.init_wr = 1'b1;
                if (cnt_reg == INIT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + ADDR_ONE;
                end
            end
            ST_STEP: begin
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_step = 1'b1;
                if (cnt_reg == last_addr) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + ADDR_ONE;
                end
            end
            ST_DRAIN: begin
                if (!dp_stat.pipe_busy) begin
                    state_next = ST_WALL;
                end
            end
            ST_WALL: begin
                dp_cmd.wall_wr = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ: begin
                dp_cmd.rd_en = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!dp_stat.out_busy) begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/lbmd1q2_dp.sv =====
module lbmd1q2_dp #(
    parameter int MAX_CELLS = 64,
    localparam int AW = $clog2(MAX_CELLS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lbmd1q2_pkg::cfg_t       cfg,
    input  lbmd1q2_pkg::dp_cmd_t    dp_cmd,
    output lbmd1q2_pkg::dp_stat_t   dp_stat,
    input  logic [AW-1:0]           cell_addr,
    input  logic [AW-1:0]           last_addr,
    input  logic [5:0]              s_cell_index,
    input  logic signed [31:0]      s_init_temp,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [31:0]      m_temperature,
    output logic signed [31:0]      m_flux_diff,
    output logic [5:0]              m_read_index
);
    import lbmd1q2_pkg::*;

    localparam logic [AW-1:0] ADDR_ONE = AW'(1);

    logic signed [31:0] rmov_mem [MAX_CELLS];
    logic signed [31:0] lmov_mem [MAX_CELLS];

    logic [5:0]         idx_reg;
    logic signed [31:0] temp_reg;
    logic               inrange_reg;

    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_r_reg, rd_l_reg;

    logic               wr_r_en, wr_l_en;
    logic [AW-1:0]      wr_r_addr, wr_l_addr;
    logic signed [31:0] wr_r_data, wr_l_data;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]      idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [31:0] f2r_reg, f2l_reg, f3r_reg, f3l_reg, f4r_reg, f4l_reg;
    logic signed [32:0] d2r_reg, d2l_reg;
    logic signed [63:0] p3r_reg, p3l_reg;
    logic signed [33:0] q4r_reg, q4l_reg;

    logic signed [31:0] rprev_reg, rlast_reg, l1_reg;

    logic signed [32:0] sum_s2, feq_s2, dr_s2, dl_s2;
    logic signed [31:0] omega_s;
    logic signed [64:0] prod_r, prod_l;
    logic signed [63:0] rnd_r, rnd_l;
    logic signed [31:0] r_new, l_new, half, wall_left, wall_right;

    logic               m_tvalid_reg;
    logic signed [31:0] m_temperature_reg, m_flux_diff_reg;
    logic [5:0]         m_read_index_reg;

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_item) begin
            idx_reg     <= s_cell_index;
            temp_reg    <= s_init_temp;
            inrange_reg <= (int'(s_cell_index) < MAX_CELLS);
        end
    end

    assign rd_addr = dp_cmd.rd_step ? cell_addr : AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (wr_r_en) begin
            rmov_mem[wr_r_addr] <= wr_r_data;
        end
        if (wr_l_en) begin
            lmov_mem[wr_l_addr] <= wr_l_data;
        end
        if (dp_cmd.rd_en) begin
            rd_r_reg <= rmov_mem[rd_addr];
            rd_l_reg <= lmov_mem[rd_addr];
        end
    end

    assign sum_s2  = 33'(rd_r_reg) + 33'(rd_l_reg);
    assign feq_s2  = sum_s2 >>> 1;
    assign dr_s2   = feq_s2 - 33'(rd_r_reg);
    assign dl_s2   = feq_s2 - 33'(rd_l_reg);
    assign omega_s = $signed({1'b0, cfg.relax_rate});
    assign prod_r  = d2r_reg * omega_s;
    assign prod_l  = d2l_reg * omega_s;
    assign rnd_r   = p3r_reg + ROUND_HALF;
    assign rnd_l   = p3l_reg + ROUND_HALF;
    assign r_new   = sat32(35'(f4r_reg) + 35'(q4r_reg));
    assign l_new   = sat32(35'(f4l_reg) + 35'(q4l_reg));
    assign half    = temp_reg >>> 1;

    assign wall_left = cfg.boundary_mode ? sat32(35'(l1_reg) + 35'(cfg.left_flux_term))
                                         : sat32(35'(cfg.left_wall) - 35'(l1_reg));
    assign wall_right = sat32(35'(cfg.right_wall) - 35'(rlast_reg));

    // The right-moving value of a cell goes to the next cell up and the left-moving value
    // to the cell below; both targets have already been read when the write happens.
    always_comb begin
        wr_r_en   = 1'b0;
        wr_l_en   = 1'b0;
        wr_r_addr = cell_addr;
        wr_l_addr = cell_addr;
        wr_r_data = half;
        wr_l_data = half;
        if (dp_cmd.init_wr) begin
            wr_r_en = 1'b1;
            wr_l_en = 1'b1;
        end else if (dp_cmd.wall_wr) begin
            wr_r_en   = 1'b1;
            wr_l_en   = 1'b1;
            wr_r_addr = '0;
            wr_l_addr = last_addr;
            wr_r_data = wall_left;
            wr_l_data = wall_right;
        end else if (v4_reg && (idx4_reg != '0)) begin
            wr_r_en   = 1'b1;
            wr_l_en   = 1'b1;
            wr_r_addr = idx4_reg;
            wr_l_addr = idx4_reg - ADDR_ONE;
            wr_r_data = rprev_reg;
            wr_l_data = l_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= dp_cmd.rd_en & dp_cmd.rd_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= cell_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        f2r_reg  <= rd_r_reg;
        f2l_reg  <= rd_l_reg;
        d2r_reg  <= dr_s2;
        d2l_reg  <= dl_s2;
        f3r_reg  <= f2r_reg;
        f3l_reg  <= f2l_reg;
        p3r_reg  <= prod_r[63:0];
        p3l_reg  <= prod_l[63:0];
        f4r_reg  <= f3r_reg;
        f4l_reg  <= f3l_reg;
        q4r_reg  <= rnd_r[63:OMEGA_BITS];
        q4l_reg  <= rnd_l[63:OMEGA_BITS];
        if (v4_reg) begin
            rprev_reg <= r_new;
            if (idx4_reg != '0) begin
                rlast_reg <= rprev_reg;
            end
            if (idx4_reg == ADDR_ONE) begin
                l1_reg <= l_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dp_cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.out_load) begin
            m_temperature_reg <= inrange_reg ? sat32(35'(rd_r_reg) + 35'(rd_l_reg)) : '0;
            m_flux_diff_reg   <= inrange_reg ? sat32(35'(rd_r_reg) - 35'(rd_l_reg)) : '0;
            m_read_index_reg  <= idx_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_temperature = m_temperature_reg;
    assign m_flux_diff   = m_flux_diff_reg;
    assign m_read_index  = m_read_index_reg;

    assign dp_stat.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign dp_stat.out_busy  = m_tvalid_reg & ~m_tready;

endmodule

// ===== hw/rtl/lbm_d1q2_heat_diffusion_step_core.sv =====
// Init writes half of init_temp once to each of the MAX_CELLS cells of both distribution memories.
// In a step, one of the n cells in use enters the collision pipeline per cycle, four
// stages deep; after the pipeline drains, the wall writes update both boundary cells.
// A read passes through the READ and OUT states before its result is registered; the next
// item may be taken while that result waits. Reset clears control state and loads the
// register defaults; the distribution memories are not cleared.
module lbm_d1q2_heat_diffusion_step_core #(
    parameter int MAX_CELLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // cell_index [5:0], init_temp [37:6], zero fill
    input  logic [1:0]  s_tuser,    // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // temperature [31:0], flux_diff [63:32], read_index [69:64]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbmd1q2_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);

    logic [30:0]        relax_rate_reg;
    logic signed [31:0] left_wall_reg, right_wall_reg, left_flux_term_reg;
    logic               boundary_mode_reg;
    logic [6:0]         cell_count_reg;

    cfg_t               cfg;
    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    logic [AW-1:0]      cell_addr, last_addr;
    logic signed [31:0] m_temperature, m_flux_diff;
    logic [5:0]         m_read_index;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_rate_reg     <= 31'd1073741824;
            left_wall_reg      <= 32'sd16777216;
            right_wall_reg     <= '0;
            left_flux_term_reg <= '0;
            boundary_mode_reg  <= 1'b0;
            cell_count_reg     <= 7'd64;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_RELAX_RATE:     relax_rate_reg     <= pwdata[30:0];
                REG_LEFT_WALL:      left_wall_reg      <= pwdata;
                REG_RIGHT_WALL:     right_wall_reg     <= pwdata;
                REG_LEFT_FLUX_TERM: left_flux_term_reg <= pwdata;
                REG_BOUNDARY_MODE:  boundary_mode_reg  <= pwdata[0];
                REG_CELL_COUNT:     cell_count_reg     <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_RELAX_RATE:     prdata = {1'b0, relax_rate_reg};
            REG_LEFT_WALL:      prdata = left_wall_reg;
            REG_RIGHT_WALL:     prdata = right_wall_reg;
            REG_LEFT_FLUX_TERM: prdata = left_flux_term_reg;
            REG_BOUNDARY_MODE:  prdata = {31'd0, boundary_mode_reg};
            REG_CELL_COUNT:     prdata = {25'd0, cell_count_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.relax_rate     = relax_rate_reg;
    assign cfg.left_wall      = left_wall_reg;
    assign cfg.right_wall     = right_wall_reg;
    assign cfg.left_flux_term = left_flux_term_reg;
    assign cfg.boundary_mode  = boundary_mode_reg;

    lbmd1q2_ctrl #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_cmd      (s_tuser),
        .cell_count (cell_count_reg),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .cell_addr  (cell_addr),
        .last_addr  (last_addr)
    );

    lbmd1q2_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .cell_addr     (cell_addr),
        .last_addr     (last_addr),
        .s_cell_index  (s_tdata[5:0]),
        .s_init_temp   (s_tdata[37:6]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_temperature (m_temperature),
        .m_flux_diff   (m_flux_diff),
        .m_read_index  (m_read_index)
    );

    assign m_tdata = {2'b00, m_read_index, m_flux_diff, m_temperature};

    a_no_accept_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.pipe_busy |-> !s_tready)
        else $error("Input transfer possible while the step pipeline is busy.");

    a_wall_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.wall_wr |-> !dp_stat.pipe_busy)
        else $error("Wall update issued before the step pipeline drained.");

    a_init_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.init_wr |-> (!dp_cmd.rd_en && !dp_stat.pipe_busy && !dp_cmd.wall_wr))
        else $error("Init sweep overlaps other memory traffic.");

endmodule

// ===== bench/tb.sv =====
module tb;
    import lbmd1q2_pkg::*;

    localparam int NUM_CELLS = 64;
    localparam int SETTLE_CYCLES = 150;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic signed [31:0] temperature;
        logic signed [31:0] flux_diff;
        logic [5:0]         read_index;
    } cell_reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // cell_index [5:0], init_temp [37:6], zero fill
    logic [1:0]  s_tuser = '0;    // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // temperature [31:0], flux_diff [63:32], read_index [69:64]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lbm_d1q2_heat_diffusion_step_core #(
        .MAX_CELLS(NUM_CELLS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the lattice and of the registers.
    logic signed [31:0] lat_right [NUM_CELLS];
    logic signed [31:0] lat_left [NUM_CELLS];
    logic [30:0]        omega_q30 = 31'h40000000;
    logic signed [31:0] wall_left = 32'sh01000000;
    logic signed [31:0] wall_right = 32'sh0;
    logic signed [31:0] flux_left = 32'sh0;
    logic               flux_mode = 1'b0;
    logic [6:0]         cells_cfg = 7'd64;

    cell_reading_t pending_readings[$];
    cell_reading_t want_reading;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int mismatches = 0;
    int inits_sent = 0;
    int steps_sent = 0;
    int reads_checked = 0;
    int reg_writes = 0;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] relax_toward(input logic signed [31:0] f,
                                                        input longint feq);
        longint d;
        longint p;
        d = feq - longint'(f);
        p = d * longint'(omega_q30) + (64'sd1 <<< (OMEGA_BITS - 1));
        return clamp32(longint'(f) + (p >>> OMEGA_BITS));
    endfunction

    function automatic void advance_lattice();
        int n;
        int i;
        longint feq;
        logic signed [31:0] nr;
        logic signed [31:0] nl;
        n = (cells_cfg < 2) ? 2 : ((cells_cfg > NUM_CELLS) ? NUM_CELLS : int'(cells_cfg));
        for (i = 0; i < n; i++) begin
            feq = (longint'(lat_right[i]) + longint'(lat_left[i])) >>> 1;
            nr = relax_toward(lat_right[i], feq);
            nl = relax_toward(lat_left[i], feq);
            lat_right[i] = nr;
            lat_left[i] = nl;
        end
        for (i = n - 1; i > 0; i--) begin
            lat_right[i] = lat_right[i - 1];
        end
        for (i = 0; i + 1 < n; i++) begin
            lat_left[i] = lat_left[i + 1];
        end
        if (flux_mode) begin
            lat_right[0] = clamp32(longint'(lat_left[0]) + longint'(flux_left));
        end else begin
            lat_right[0] = clamp32(longint'(wall_left) - longint'(lat_left[0]));
        end
        lat_left[n - 1] = clamp32(longint'(wall_right) - longint'(lat_right[n - 1]));
    endfunction

    function automatic void lattice_take_item(input logic [1:0] cmd, input logic [5:0] idx,
                                              input logic signed [31:0] temp);
        cell_reading_t r;
        int i;
        case (cmd)
            CMD_INIT: begin
                for (i = 0; i < NUM_CELLS; i++) begin
                    lat_right[i] = temp >>> 1;
                    lat_left[i] = temp >>> 1;
                end
                inits_sent++;
            end
            CMD_STEP: begin
                advance_lattice();
                steps_sent++;
            end
            CMD_READ: begin
                r.temperature = clamp32(longint'(lat_right[idx]) + longint'(lat_left[idx]));
                r.flux_diff = clamp32(longint'(lat_right[idx]) - longint'(lat_left[idx]));
                r.read_index = idx;
                pending_readings.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [31:0] temp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, temp, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lattice_take_item(cmd, idx, temp);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_RELAX_RATE:     omega_q30 = value[30:0];
            REG_LEFT_WALL:      wall_left = value;
            REG_RIGHT_WALL:     wall_right = value;
            REG_LEFT_FLUX_TERM: flux_left = value;
            REG_BOUNDARY_MODE:  flux_mode = value[0];
            REG_CELL_COUNT:     cells_cfg = value[6:0];
            default: begin
            end
        endcase
        reg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all_regs(input logic [31:0] omega, input logic [31:0] lw,
                                input logic [31:0] rw, input logic [31:0] flux,
                                input logic [31:0] mode, input logic [31:0] cnt);
        write_reg(REG_RELAX_RATE, omega);
        write_reg(REG_LEFT_WALL, lw);
        write_reg(REG_RIGHT_WALL, rw);
        write_reg(REG_LEFT_FLUX_TERM, flux);
        write_reg(REG_BOUNDARY_MODE, mode);
        write_reg(REG_CELL_COUNT, cnt);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [31:0] omega;
        logic [31:0] cnt;
        case ($urandom_range(4))
            0: omega = 32'h0;
            1: omega = 32'h7fffffff;
            2: omega = 32'h40000000;
            default: omega = $urandom;
        endcase
        case ($urandom_range(9))
            0: cnt = 64;
            1: cnt = $urandom_range(127);
            default: cnt = $urandom_range(2, 10);
        endcase
        set_all_regs(omega, rand_word(), rand_word(), rand_word(), $urandom_range(1), cnt);
    endtask

    task automatic run_random(input int count);
        int k;
        int r;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_item(CMD_INIT, 6'($urandom), rand_word());
            end else if (r < 30) begin
                send_item(CMD_STEP, 6'($urandom), $urandom);
            end else if (r < 95) begin
                send_item(CMD_READ, 6'($urandom_range(63)), $urandom);
            end else begin
                send_item(CMD_UNUSED, 6'($urandom), $urandom);
            end
        end
    endtask

    task automatic extremes_burst(input logic [31:0] temp);
        send_item(CMD_INIT, 6'h00, temp);
        send_item(CMD_STEP, 6'h3f, 32'h0);
        send_item(CMD_READ, 6'd0, 32'hffffffff);
        send_item(CMD_STEP, 6'h00, 32'hffffffff);
        send_item(CMD_READ, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd1, 32'h0);
        send_item(CMD_STEP, 6'h15, 32'h0);
        send_item(CMD_READ, 6'd62, 32'h0);
        send_item(CMD_READ, 6'd63, 32'h0);
        send_item(CMD_READ, 6'($urandom_range(63)), $urandom);
    endtask

    task automatic test_directed();
        send_item(CMD_INIT, 6'h3f, 32'h7fffffff);
        send_item(CMD_READ, 6'd0, 32'hffffffff);
        send_item(CMD_READ, 6'd63, 32'h0);
        send_item(CMD_INIT, 6'h00, 32'h80000000);
        send_item(CMD_READ, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd63, 32'h0);
        send_item(CMD_UNUSED, 6'h3f, 32'hffffffff);
        send_item(CMD_READ, 6'd5, 32'h0);
        send_item(CMD_INIT, 6'h2a, 32'h01000000);
        send_item(CMD_STEP, 6'h00, 32'h0);
        send_item(CMD_STEP, 6'h00, 32'h0);
        send_item(CMD_STEP, 6'h00, 32'h0);
        send_item(CMD_READ, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd1, 32'h0);
        send_item(CMD_READ, 6'd2, 32'h0);
        send_item(CMD_READ, 6'd63, 32'h0);
        send_item(CMD_INIT, 6'h15, 32'hffffffff);
        send_item(CMD_READ, 6'd10, 32'h0);
        send_item(CMD_STEP, 6'h00, 32'h0);
        send_item(CMD_READ, 6'd0, 32'h0);
        send_item(CMD_READ, 6'd62, 32'h0);
        send_item(CMD_READ, 6'd63, 32'h0);
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        set_all_regs(32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'd0);
        extremes_burst(32'h80000000);
        drain_pipeline();
        set_all_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'd127);
        extremes_burst(32'h7fffffff);
        drain_pipeline();
        set_all_regs(32'h40000000, rand_word(), rand_word(), 32'h80000000, 32'h1, 32'd1);
        extremes_burst(32'h80000000);
        drain_pipeline();
        set_all_regs(32'h40000000, rand_word(), rand_word(), 32'h0, 32'h0, 32'd65);
        extremes_burst($urandom);
        drain_pipeline();
        set_all_regs(32'h55555555, 32'h01000000, 32'h0, 32'h00800000, 32'h0, 32'd2);
        extremes_burst(32'h02000000);
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        int m;
        for (m = 0; m < 4; m++) begin
            case (m)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            random_config();
            run_random(70);
            drain_pipeline();
            random_config();
            run_random(70);
            drain_pipeline();
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_all_regs(32'h40000000, 32'h01000000, 32'h0, 32'h0, 32'h0, 32'd8);
        send_item(CMD_INIT, 6'h00, 32'h03000000);
        hold_req = 400;
        for (k = 0; k < 30; k++) begin
            if (k % 6 == 5) begin
                send_item(CMD_STEP, 6'($urandom), $urandom);
            end else begin
                send_item(CMD_READ, 6'($urandom_range(63)), $urandom);
            end
        end
        drain_pipeline();
    endtask

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result transfer with no read pending: %h", m_tdata);
                end
            end else begin
                want_reading = pending_readings.pop_front();
                reads_checked++;
                if (m_tdata[31:0] !== want_reading.temperature ||
                    m_tdata[63:32] !== want_reading.flux_diff ||
                    m_tdata[69:64] !== want_reading.read_index) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Read mismatch: temperature exp %h got %h, flux_diff exp %h got %h,",
                                 want_reading.temperature, m_tdata[31:0],
                                 want_reading.flux_diff, m_tdata[63:32]);
                        $display("    read_index exp %0d got %0d",
                                 want_reading.read_index, m_tdata[69:64]);
                    end
                end
            end
        end
    end

    initial begin
        #10000000;
        $display("Run did not finish in time.");
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            lat_right[i] = '0;
            lat_left[i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        $display("Covered %0d inits, %0d steps, %0d checked reads, %0d register writes,",
                 inits_sent, steps_sent, reads_checked, reg_writes);
        $display("across four pacing modes, wall extremes, both wall modes and a long stall.");
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d reads never returned.",
                     mismatches, pending_readings.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
